>>> sv/ip_pair_traffic_matrix_assert.svh
// Assertion macros for the IP pair traffic matrix checker.
// Needs i_clk and i_rst_n in the scope of use.
`ifndef IP_PAIR_TRAFFIC_MATRIX_ASSERT_SVH
`define IP_PAIR_TRAFFIC_MATRIX_ASSERT_SVH

// same-cycle implication
`define PTM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("traffic matrix check failed");

// next-cycle implication
`define PTM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("traffic matrix check failed");

`endif

>>> sv/ptm_pkg.sv
// Shared types for the IP pair traffic matrix.
// No dependencies.
package ptm_pkg;

    localparam logic [7:0] TCP_PROTOCOL = 8'd6;
    localparam int ADDR_W = 32;
    localparam int LEN_W  = 16;
    localparam int PKT_W  = 32;
    localparam int VOL_W  = 48;

    // item travelling along the cell chain
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        logic [LEN_W-1:0]  payload;
    } t_item;

    // contents of one table entry
    typedef struct packed {
        logic              used;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        logic [PKT_W-1:0]  pkts;
        logic [VOL_W-1:0]  vol;
    } t_entry;

endpackage

>>> sv/ip_pair_traffic_matrix.sv
// A record walks the cell chain through each cell's item register; one record per
// cycle while o_in_stall is low. A dump waits for the chain to drain, then shifts the
// chain FLOW_ENTRIES times, one shift per cycle the result register is free, taking
// each result from the top cell as it shifts; an empty table gives one empty result.
// Reset (synchronous, active low) empties the table and clears the overflow flag.
// Top level of the traffic matrix; depends on ptm_pkg and ptm_cell.
module ip_pair_traffic_matrix #(
    parameter int FLOW_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic        i_has_ip_header,
    input  logic        i_has_tcp_header,
    input  logic [7:0]  i_protocol,
    input  logic [15:0] i_total_length,
    input  logic [3:0]  i_ip_header_words,
    input  logic [3:0]  i_tcp_offset_words,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_entry_src,
    output logic [31:0] o_entry_dst,
    output logic [31:0] o_packet_count,
    output logic [47:0] o_byte_volume,
    output logic        o_entry_valid,
    output logic        o_overflow_seen,
    output logic        o_last
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DRAIN = 4'b0010,
        S_DUMP  = 4'b0100,
        S_EMPTY = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic               r_ovf;
    logic               r_out_valid;
    logic [31:0]        r_src, r_dst, r_pkts;
    logic [47:0]        r_vol;
    logic               r_ev, r_last, r_ovf_out;
    ptm_pkg::t_item     w_item [0:FLOW_ENTRIES];
    ptm_pkg::t_entry    w_ent  [0:FLOW_ENTRIES-1];
    logic [FLOW_ENTRIES-1:0] live;
    logic               accept, counted, out_free, shift;
    logic [6:0]         hdr;
    logic [15:0]        payload;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign counted  = i_has_ip_header && i_has_tcp_header
                      && (i_protocol == ptm_pkg::TCP_PROTOCOL);
    assign hdr      = {1'b0, i_ip_header_words, 2'b00} + {1'b0, i_tcp_offset_words, 2'b00};
    assign payload  = (i_total_length > {9'd0, hdr}) ? i_total_length - {9'd0, hdr} : 16'd0;
    assign out_free = !r_out_valid || !i_out_stall;
    assign shift    = (r_state == S_DUMP) && out_free;

    assign w_item[0] = '{valid: accept && !i_action && counted,
                         src: i_src_addr, dst: i_dst_addr, payload: payload};

    // chain of entry cells
    for (genvar g = 0; g < FLOW_ENTRIES; g++) begin : g_cell
        ptm_pkg::t_entry prev;
        if (g == 0) begin : g_first
            assign prev = '0;
        end else begin : g_rest
            assign prev = w_ent[g-1];
        end
        ptm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_item  (w_item[g]),
            .i_prev  (prev),
            .o_item  (w_item[g+1]),
            .o_entry (w_ent[g])
        );
        assign live[g] = w_item[g+1].valid;
    end

    // dump sequencing
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept && i_action) n_state = S_DRAIN;
            S_DRAIN: if (!(|live)) n_state = w_ent[0].used ? S_DUMP : S_EMPTY;
            S_DUMP:  if (shift && w_ent[FLOW_ENTRIES-1].used
                         && !w_ent[FLOW_ENTRIES-2].used) n_state = S_IDLE;
            S_EMPTY: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // an item falling off the end found no room
            if (w_item[FLOW_ENTRIES].valid) r_ovf <= 1'b1;
            if (shift && w_ent[FLOW_ENTRIES-1].used) r_out_valid <= 1'b1;
            else if (r_state == S_EMPTY && out_free) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
        // result register; the flag is captured so a held item keeps its value
        if (shift && w_ent[FLOW_ENTRIES-1].used) begin
            r_src     <= w_ent[FLOW_ENTRIES-1].src;
            r_dst     <= w_ent[FLOW_ENTRIES-1].dst;
            r_pkts    <= w_ent[FLOW_ENTRIES-1].pkts;
            r_vol     <= w_ent[FLOW_ENTRIES-1].vol;
            r_ev      <= 1'b1;
            r_last    <= !w_ent[FLOW_ENTRIES-2].used;
            r_ovf_out <= r_ovf;
        end else if (r_state == S_EMPTY && out_free) begin
            r_src     <= '0;
            r_dst     <= '0;
            r_pkts    <= '0;
            r_vol     <= '0;
            r_ev      <= 1'b0;
            r_last    <= 1'b1;
            r_ovf_out <= r_ovf;
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_entry_src     = r_src;
    assign o_entry_dst     = r_dst;
    assign o_packet_count  = r_pkts;
    assign o_byte_volume   = r_vol;
    assign o_entry_valid   = r_ev;
    assign o_overflow_seen = r_ovf_out;
    assign o_last          = r_last;

endmodule

>>> sv/ptm_cell.sv
// One table entry of the traffic matrix with its item stage.
// Depends on ptm_pkg.
module ptm_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  ptm_pkg::t_item  i_item,
    input  ptm_pkg::t_entry i_prev,
    output ptm_pkg::t_item  o_item,
    output ptm_pkg::t_entry o_entry
);

    logic                          r_used, n_used;
    logic [ptm_pkg::ADDR_W-1:0]    r_src, n_src, r_dst, n_dst;
    logic [ptm_pkg::PKT_W-1:0]     r_pkts, n_pkts;
    logic [ptm_pkg::VOL_W-1:0]     r_vol, n_vol;
    logic                          r_ivalid, n_ivalid;
    logic [ptm_pkg::ADDR_W-1:0]    r_isrc, r_idst;
    logic [ptm_pkg::LEN_W-1:0]     r_ipay;
    logic                          match;
    logic [ptm_pkg::VOL_W:0]       vol_sum;

    assign match   = r_used && (r_src == i_item.src) && (r_dst == i_item.dst);
    assign vol_sum = {1'b0, r_vol} + {{(ptm_pkg::VOL_W-ptm_pkg::LEN_W+1){1'b0}}, i_item.payload};

    // a shift copies the previous entry; else a hit updates, a free cell claims, otherwise the item moves on
    always_comb begin
        n_used   = r_used;
        n_src    = r_src;
        n_dst    = r_dst;
        n_pkts   = r_pkts;
        n_vol    = r_vol;
        n_ivalid = 1'b0;
        if (i_shift) begin
            n_used = i_prev.used;
            n_src  = i_prev.src;
            n_dst  = i_prev.dst;
            n_pkts = i_prev.pkts;
            n_vol  = i_prev.vol;
        end else if (i_item.valid) begin
            if (match) begin
                if (r_pkts != '1) n_pkts = r_pkts + 1'b1;
                n_vol = vol_sum[ptm_pkg::VOL_W] ? '1 : vol_sum[ptm_pkg::VOL_W-1:0];
            end else if (!r_used) begin
                n_used = 1'b1;
                n_src  = i_item.src;
                n_dst  = i_item.dst;
                n_pkts = {{(ptm_pkg::PKT_W-1){1'b0}}, 1'b1};
                n_vol  = {{(ptm_pkg::VOL_W-ptm_pkg::LEN_W){1'b0}}, i_item.payload};
            end else begin
                n_ivalid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= 1'b0;
            r_ivalid <= 1'b0;
        end else begin
            r_used   <= n_used;
            r_ivalid <= n_ivalid;
        end
        r_src  <= n_src;
        r_dst  <= n_dst;
        r_pkts <= n_pkts;
        r_vol  <= n_vol;
        r_isrc <= i_item.src;
        r_idst <= i_item.dst;
        r_ipay <= i_item.payload;
    end

    assign o_item  = '{valid: r_ivalid, src: r_isrc, dst: r_idst, payload: r_ipay};
    assign o_entry = '{used: r_used, src: r_src, dst: r_dst, pkts: r_pkts, vol: r_vol};

endmodule

>>> sv/ptm_checker.sv
// Port-level checks for the traffic matrix, bound to the top level.
// Depends on ip_pair_traffic_matrix_assert.svh.
`include "ip_pair_traffic_matrix_assert.svh"

module ptm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_entry_src,
    input logic        o_entry_valid,
    input logic        o_last
);

    // a dump streams its results without gaps
    `PTM_ASSERT_NEXT(a_dump_no_gap, o_out_valid && !o_last, o_out_valid)
    // input held off while a dump is still running
    `PTM_ASSERT_NOW(a_dump_blocks_in, o_out_valid && !o_last, o_in_stall)
    // an empty-table result is always the final one
    `PTM_ASSERT_NOW(a_empty_is_last, o_out_valid && !o_entry_valid, o_last)
    // stalled item holds
    `PTM_ASSERT_NEXT(a_hold, o_out_valid && i_out_stall, $stable(o_entry_src) && o_out_valid)

endmodule

bind ip_pair_traffic_matrix ptm_checker u_ptm_checker (.*);

>>> dv/tb.sv
// Self-checking testbench for the IP pair traffic matrix (ip_pair_traffic_matrix).
// Depends on ptm_pkg and the block RTL; predicts dump results from its own flow table.
`timescale 1ns / 1ps

module tb;

    localparam int ENTRIES   = 64;
    localparam int WDOG_MAX  = 20000;

    typedef struct {
        logic [31:0] src;
        logic [31:0] dst;
        logic [31:0] pkts;
        logic [47:0] vol;
        logic        valid;
        logic        ovf;
        logic        last;
    } t_dump_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_action = 1'b0;
    logic [31:0] i_src_addr = '0;
    logic [31:0] i_dst_addr = '0;
    logic        i_has_ip_header = 1'b0;
    logic        i_has_tcp_header = 1'b0;
    logic [7:0]  i_protocol = '0;
    logic [15:0] i_total_length = '0;
    logic [3:0]  i_ip_header_words = '0;
    logic [3:0]  i_tcp_offset_words = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b1;
    logic [31:0] o_entry_src;
    logic [31:0] o_entry_dst;
    logic [31:0] o_packet_count;
    logic [47:0] o_byte_volume;
    logic        o_entry_valid;
    logic        o_overflow_seen;
    logic        o_last;

    // predicted flow table
    logic [31:0] flow_src [ENTRIES];
    logic [31:0] flow_dst [ENTRIES];
    logic [31:0] flow_pkts [ENTRIES];
    logic [47:0] flow_vol [ENTRIES];
    int          flows_used = 0;
    bit          flow_overflow = 1'b0;

    t_dump_row   dump_rows [$];
    int          n_fail = 0;
    int          idle_cycles = 0;
    logic [31:0] pool_src [8];
    logic [31:0] pool_dst [8];

    ip_pair_traffic_matrix u_top (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // update the predicted table with one accepted item
    function automatic void predict_item(logic act, logic [31:0] s, logic [31:0] d,
                                         logic hip, logic htcp, logic [7:0] pr,
                                         logic [15:0] tot, logic [3:0] ihl,
                                         logic [3:0] doff);
        logic [16:0] hdr;
        logic [47:0] pay;
        t_dump_row   r;
        bit          found;
        found = 1'b0;
        if (!act) begin
            if (!(hip && htcp && pr == ptm_pkg::TCP_PROTOCOL)) return;
            hdr = {11'd0, ihl, 2'b00} + {11'd0, doff, 2'b00};
            pay = ({1'b0, tot} > hdr) ? 48'({1'b0, tot} - hdr) : 48'd0;
            for (int i = 0; i < flows_used; i++) begin
                if (!found && flow_src[i] == s && flow_dst[i] == d) begin
                    found = 1'b1;
                    if (flow_pkts[i] != '1) flow_pkts[i]++;
                    flow_vol[i] = (48'hFFFF_FFFF_FFFF - flow_vol[i] < pay) ?
                                  48'hFFFF_FFFF_FFFF : flow_vol[i] + pay;
                end
            end
            if (found) return;
            if (flows_used >= ENTRIES) begin
                flow_overflow = 1'b1;
                return;
            end
            flow_src[flows_used]  = s;
            flow_dst[flows_used]  = d;
            flow_pkts[flows_used] = 32'd1;
            flow_vol[flows_used]  = pay;
            flows_used++;
            return;
        end
        // dump: newest first, then clear
        if (flows_used == 0) begin
            r = '{src: '0, dst: '0, pkts: '0, vol: '0, valid: 1'b0,
                  ovf: flow_overflow, last: 1'b1};
            dump_rows.push_back(r);
            return;
        end
        for (int i = flows_used - 1; i >= 0; i--) begin
            r = '{src: flow_src[i], dst: flow_dst[i], pkts: flow_pkts[i],
                  vol: flow_vol[i], valid: 1'b1, ovf: flow_overflow, last: (i == 0)};
            dump_rows.push_back(r);
        end
        flows_used = 0;
    endfunction

    // send one item with a random gap before it
    task automatic send_item(logic act, logic [31:0] s, logic [31:0] d, logic hip,
                             logic htcp, logic [7:0] pr, logic [15:0] tot,
                             logic [3:0] ihl, logic [3:0] doff);
        int gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_src_addr <= s;
        i_dst_addr <= d;
        i_has_ip_header <= hip;
        i_has_tcp_header <= htcp;
        i_protocol <= pr;
        i_total_length <= tot;
        i_ip_header_words <= ihl;
        i_tcp_offset_words <= doff;
        do @(posedge i_clk); while (o_in_stall);
        predict_item(act, s, d, hip, htcp, pr, tot, ihl, doff);
        @(negedge i_clk);
    endtask

    task automatic send_tcp(logic [31:0] s, logic [31:0] d, logic [15:0] tot,
                            logic [3:0] ihl, logic [3:0] doff);
        send_item(1'b0, s, d, 1'b1, 1'b1, ptm_pkg::TCP_PROTOCOL, tot, ihl, doff);
    endtask

    task automatic send_dump();
        send_item(1'b1, $urandom, $urandom, 1'($urandom), 1'($urandom), 8'($urandom),
                  16'($urandom), 4'($urandom), 4'($urandom));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (dump_rows.size() != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    // receiver: per result, hold stall for a random number of cycles, then take it
    initial begin : rx_side
        int wait_n;
        forever begin
            wait_n = $urandom_range(0, 11);
            repeat (wait_n) begin
                i_out_stall <= 1'b1;
                @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            @(negedge i_clk);
        end
    end

    // check every accepted result against the oldest prediction
    always @(posedge i_clk) begin
        t_dump_row e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (dump_rows.size() == 0) begin
                $error("unexpected result src=%h", o_entry_src);
                n_fail++;
            end else begin
                e = dump_rows.pop_front();
                if (o_entry_src !== e.src) begin
                    $error("entry_src exp %h got %h", e.src, o_entry_src); n_fail++;
                end
                if (o_entry_dst !== e.dst) begin
                    $error("entry_dst exp %h got %h", e.dst, o_entry_dst); n_fail++;
                end
                if (o_packet_count !== e.pkts) begin
                    $error("packet_count exp %h got %h", e.pkts, o_packet_count); n_fail++;
                end
                if (o_byte_volume !== e.vol) begin
                    $error("byte_volume exp %h got %h", e.vol, o_byte_volume); n_fail++;
                end
                if (o_entry_valid !== e.valid) begin
                    $error("entry_valid exp %b got %b", e.valid, o_entry_valid); n_fail++;
                end
                if (o_overflow_seen !== e.ovf) begin
                    $error("overflow_seen exp %b got %b", e.ovf, o_overflow_seen); n_fail++;
                end
                if (o_last !== e.last) begin
                    $error("last exp %b got %b", e.last, o_last); n_fail++;
                end
            end
        end
    end

    // watchdog: cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // extremes of fields, empty dump, header gating, negative payload
    task automatic test_directed();
        send_dump();
        send_tcp(32'h0, 32'h0, 16'h0, 4'h0, 4'h0);
        send_tcp(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 4'hF, 4'hF);
        send_tcp(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 4'h0, 4'h0);
        send_tcp(32'hAAAA_5555, 32'h5555_AAAA, 16'd20, 4'd5, 4'd5);
        send_tcp(32'h5555_AAAA, 32'hAAAA_5555, 16'd100, 4'd5, 4'd5);
        send_item(1'b0, 32'h1, 32'h2, 1'b0, 1'b1, ptm_pkg::TCP_PROTOCOL, 16'd99, 4'd5, 4'd5);
        send_item(1'b0, 32'h1, 32'h2, 1'b1, 1'b0, ptm_pkg::TCP_PROTOCOL, 16'd99, 4'd5, 4'd5);
        send_item(1'b0, 32'h1, 32'h2, 1'b1, 1'b1, 8'd17, 16'd99, 4'd5, 4'd5);
        send_item(1'b0, 32'h1, 32'h2, 1'b1, 1'b1, 8'hFF, 16'd99, 4'd5, 4'd5);
        send_tcp(32'hAAAA_5555, 32'h5555_AAAA, 16'd1500, 4'd5, 4'd8);
        send_dump();
        send_dump();
        wait_drained();
    endtask

    // fill the table past full: overflow flag must stick through dumps
    task automatic test_overflow();
        for (int i = 0; i < ENTRIES + 3; i++)
            send_tcp(32'h0A00_0000 + i, $urandom, 16'($urandom), 4'($urandom),
                     4'($urandom));
        send_tcp(32'h0A00_0000, 32'h1, 16'd40, 4'd5, 4'd5);
        send_dump();
        send_dump();
        wait_drained();
    endtask

    // random traffic over a small pool of pairs so flows recur
    task automatic test_random();
        logic [31:0] s, d;
        int k;
        for (int i = 0; i < 8; i++) begin
            pool_src[i] = $urandom;
            pool_dst[i] = $urandom;
        end
        for (int n = 0; n < 370; n++) begin
            k = $urandom_range(0, 99);
            if (k < 4) begin
                send_dump();
            end else if (k < 70) begin
                s = pool_src[$urandom_range(0, 7)];
                d = pool_dst[$urandom_range(0, 7)];
                send_tcp(s, d, 16'($urandom), 4'($urandom), 4'($urandom));
            end else if (k < 85) begin
                send_tcp($urandom, $urandom, 16'($urandom), 4'($urandom), 4'($urandom));
            end else begin
                send_item(1'b0, $urandom, $urandom, 1'($urandom), 1'($urandom),
                          ($urandom_range(0, 1) ? ptm_pkg::TCP_PROTOCOL : 8'($urandom)),
                          16'($urandom), 4'($urandom), 4'($urandom));
            end
        end
        send_dump();
        wait_drained();
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_overflow();
        test_random();
        repeat (200) @(negedge i_clk);
        if (n_fail == 0 && dump_rows.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

>>> ip_pair_traffic_matrix.f
+incdir+sv
sv/ptm_pkg.sv
sv/ptm_cell.sv
sv/ip_pair_traffic_matrix.sv
sv/ptm_checker.sv
dv/tb.sv
